// ----- rtl/core/multi_channel_echo_ranger_assert.svh -----
// Assertion macros used by the echo ranger RTL.
`ifndef MULTI_CHANNEL_ECHO_RANGER_ASSERT_SVH
`define MULTI_CHANNEL_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define MCER_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("echo ranger assertion failed");
// Next-cycle implication under reset.
`define MCER_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("echo ranger assertion failed");
`else
`define MCER_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MCER_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/mcer_pkg.sv -----
// Types and constants of the echo ranger.
`timescale 1ns / 1ps
package mcer_pkg;

   localparam int DIST_W     = 16;
   localparam int CH_FIELD_W = 3;
   localparam int DIVISOR    = 58;
   localparam int QUOT_W     = DIST_W + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic REQ_ARM   = 1'b0;
   localparam logic REQ_LEVEL = 1'b1;

   localparam logic CFG_CHANNEL_MASK = 1'b0;
   localparam logic CFG_US_PER_COUNT = 1'b1;

   localparam logic [7:0] US_PER_COUNT_RESET = 8'd16;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

// ----- rtl/core/multi_channel_echo_ranger.sv -----
// Each falling edge in a level sample adds one multiply of width by us_per_count
// (ST_MUL), then the shared divider by 58 (reciprocal multiply) and its store
// (ST_DIV). A finished round then emits CHANNELS results, one per cycle while
// rsp_tready does not hold them back; input is held off meanwhile.
// Synchronous active-high reset: idle, no round, stored starts and distances zero,
// channel_mask 0, us_per_count 16.
`timescale 1ns / 1ps
`include "multi_channel_echo_ranger_assert.svh"
module multi_channel_echo_ranger #(
   parameter int CHANNELS   = 8,
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [7:0] echo_levels, [23:8] timestamp
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [2:0] channel, [18:3] distance_value, [23:19] zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import mcer_pkg::*;

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TW = TIME_WIDTH;
   localparam int MW = TW + 8;
   localparam int PW = (MW > 23) ? MW : 23;

   state_type            state_ff, state_in;
   logic [7:0]           mask_ff, mask_in;
   logic [7:0]           us_ff, us_in;
   logic [CHANNELS-1:0]  prior_ff, prior_in;
   logic [CHANNELS-1:0]  stopped_ff, stopped_in;
   logic [CHANNELS-1:0]  fall_ff, fall_in;
   logic [TW-1:0]        start_ff [CHANNELS];
   logic [TW-1:0]        start_in [CHANNELS];
   logic [DIST_W-1:0]    dist_ff [CHANNELS];
   logic [DIST_W-1:0]    dist_in [CHANNELS];
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [TW-1:0]        ts_ff, ts_in;
   logic [CW-1:0]        cur_ch_ff, cur_ch_in;
   logic [CW-1:0]        emit_idx_ff, emit_idx_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic                 div_start_ff, div_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CH_FIELD_W-1:0] rsp_ch_ff, rsp_ch_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire;
   logic [CHANNELS-1:0]  en, cur, changed, rise, fall;
   logic                 round_done;
   logic [TW-1:0]        ts_new;
   logic [CW-1:0]        sel;
   logic [TW-1:0]        width;
   logic [MW-1:0]        prod_raw;
   logic                 div_done;
   logic [DIST_W-1:0]    div_q;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign en      = mask_ff[CHANNELS-1:0];
   assign ts_new  = TW'(req_tdata[23:8]);
   assign cur     = req_tdata[CHANNELS-1:0] & en;
   assign changed = cur ^ prior_ff;
   assign rise    = changed & cur;
   assign fall    = changed & ~cur;

   // a channel blocks the round while it has just risen or has not stopped yet
   always_comb begin
      round_done = 1'b1;
      for (int n = 0; n < CHANNELS; n++) begin
         if (en[n] && (rise[n] || (!fall[n] && !stopped_ff[n]))) begin
            round_done = 1'b0;
         end
      end
   end

   // lowest pending falling edge
   always_comb begin
      sel = '0;
      for (int n = CHANNELS - 1; n >= 0; n--) begin
         if (fall_ff[n]) begin
            sel = CW'(n);
         end
      end
   end

   // wrap drops one count: max - start + end
   always_comb begin
      if (ts_ff >= start_ff[sel]) begin
         width = ts_ff - start_ff[sel];
      end else begin
         width = ts_ff - start_ff[sel] - TW'(1);
      end
   end

   assign prod_raw = MW'(width) * MW'(us_ff);

   mcer_div #(
      .DW (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      us_in        = us_ff;
      prior_in     = prior_ff;
      stopped_in   = stopped_ff;
      fall_in      = fall_ff;
      start_in     = start_ff;
      dist_in      = dist_ff;
      active_in    = active_ff;
      done_in      = done_ff;
      ts_in        = ts_ff;
      cur_ch_in    = cur_ch_ff;
      emit_idx_in  = emit_idx_ff;
      prod_in      = prod_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CFG_CHANNEL_MASK: mask_in = csr_wdata;
            CFG_US_PER_COUNT: us_in   = csr_wdata;
            default:          mask_in = mask_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == REQ_ARM) begin
                  prior_in   = '0;
                  stopped_in = '0;
                  active_in  = 1'b1;
               end else if (active_ff) begin
                  prior_in = cur;
                  ts_in    = ts_new;
                  fall_in  = fall;
                  done_in  = round_done;
                  for (int n = 0; n < CHANNELS; n++) begin
                     if (rise[n]) begin
                        start_in[n]   = ts_new;
                        stopped_in[n] = 1'b0;
                     end
                     if (fall[n]) begin
                        stopped_in[n] = 1'b1;
                     end
                  end
                  if (fall != '0) begin
                     state_in = ST_MUL;
                  end else if (round_done) begin
                     active_in   = 1'b0;
                     emit_idx_in = '0;
                     state_in    = ST_EMIT;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_in      = PW'(prod_raw);
            cur_ch_in    = sel;
            fall_in[sel] = 1'b0;
            div_start_in = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               dist_in[cur_ch_ff] = div_q;
               if (fall_ff != '0) begin
                  state_in = ST_MUL;
               end else if (done_ff) begin
                  active_in   = 1'b0;
                  emit_idx_in = '0;
                  state_in    = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = CH_FIELD_W'(emit_idx_ff);
               rsp_dist_in  = dist_ff[emit_idx_ff];
               rsp_last_in  = (emit_idx_ff == CW'(CHANNELS - 1));
               emit_idx_in  = emit_idx_ff + CW'(1);
               if (emit_idx_ff == CW'(CHANNELS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         us_ff        <= US_PER_COUNT_RESET;
         prior_ff     <= '0;
         stopped_ff   <= '0;
         fall_ff      <= '0;
         active_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < CHANNELS; n++) begin
            start_ff[n] <= '0;
            dist_ff[n]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         us_ff        <= us_in;
         prior_ff     <= prior_in;
         stopped_ff   <= stopped_in;
         fall_ff      <= fall_in;
         active_ff    <= active_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         dist_ff      <= dist_in;
      end
      done_ff     <= done_in;
      ts_ff       <= ts_in;
      cur_ch_ff   <= cur_ch_in;
      emit_idx_ff <= emit_idx_in;
      prod_ff     <= prod_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_dist_ff, rsp_ch_ff};
   assign rsp_tlast  = rsp_last_ff;

   `MCER_ASSERT_IMPL(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, fall_ff == '0)
   `MCER_ASSERT_IMPL(a_emit_round_closed, clock, reset, state_ff == ST_EMIT, !active_ff)
   `MCER_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `MCER_ASSERT_NEXT(a_mul_starts_div, clock, reset, state_ff == ST_MUL, div_start_ff)

endmodule

// ----- rtl/core/mcer_div.sv -----
// Division by the fixed constant 58 through a reciprocal multiply, saturating at the limit.
`timescale 1ns / 1ps
module mcer_div #(
   parameter int DW = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DW-1:0]               dividend,
   output logic                        done,
   output logic [mcer_pkg::DIST_W-1:0] quotient
);
   import mcer_pkg::*;

   // dividends below 58 * 2^16 fit in 22 bits; larger ones saturate
   localparam int XW    = 22;
   localparam int RW    = 23;
   localparam int SHIFT = 28;
   localparam int PRW   = XW + RW;

   // ceil(2^28 / 58): exact floor quotient for every dividend below 2^22
   localparam logic [RW-1:0] RECIP     = 23'd4628198;
   localparam logic [DW-1:0] SAT_LIMIT = DW'(DIVISOR) << DIST_W;

   logic           done_ff, done_in;
   logic           sat_ff, sat_in;
   logic [PRW-1:0] prod_ff, prod_in;

   always_comb begin
      done_in = start;
      sat_in  = sat_ff;
      prod_in = prod_ff;
      if (start) begin
         sat_in  = (dividend >= SAT_LIMIT);
         prod_in = PRW'(dividend[XW-1:0]) * PRW'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      sat_ff  <= sat_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? DIST_MAX : prod_ff[SHIFT +: DIST_W];

endmodule
